FILE: design/gtr_pkg.sv
// Package with the constants and payload types of the glyph text renderer.
`default_nettype none

package gtr_pkg;

   // Screen size in pixels.
   localparam int SCREEN_WIDTH  = 80;
   localparam int SCREEN_HEIGHT = 60;

   // Glyph geometry and glyph store size.
   localparam int GLYPH_DIM   = 8;
   localparam int STORE_DEPTH = 2048;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // Output coordinate widths.
   localparam int PIX_COL_W = 7;
   localparam int PIX_ROW_W = 6;

   // Cursor widths; the cursor never reaches the screen size itself.
   localparam int CUR_COL_W = $clog2(SCREEN_WIDTH);
   localparam int CUR_ROW_W = $clog2(SCREEN_HEIGHT);

   // Widths used for cursor and pixel coordinate sums.
   localparam int COL_SUM_W = (CUR_COL_W + 2 > PIX_COL_W) ? CUR_COL_W + 2 : PIX_COL_W;
   localparam int ROW_SUM_W = (CUR_ROW_W + 2 > PIX_ROW_W) ? CUR_ROW_W + 2 : PIX_ROW_W;

   // Opcodes of a request.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // Request payload.
   typedef struct packed {
      logic       opcode;
      logic [7:0] char_code;
      logic [6:0] sheet_row;
      logic [6:0] sheet_col;
      logic       sheet_bit;
   } req_type;

   // Result payload.
   typedef struct packed {
      logic [PIX_COL_W-1:0] pixel_col;
      logic [PIX_ROW_W-1:0] pixel_row;
      logic                 pixel_on;
      logic                 last_pixel;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_RD,
      ST_LD_WR,
      ST_FETCH,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

FILE: design/glyph_text_renderer.sv
// Top level of the glyph text renderer: glyph store, cursor and pixel sequencer.
//
//   channel   ports                           direction   handshake
//   request   start, busy, req_data           in          start && !busy
//   result    rsp_valid, rsp_data             out         rsp_valid, one cycle
//
// A draw request does one glyph store read, then 64 pixels at one per cycle, set by
// the single result port, and returns to idle, where the next request is taken; the
// next glyph row is read during the eighth pixel of the current row. A load request
// of a set pixel reads, ORs and writes back the glyph store row, then returns to idle;
// one of a clear pixel stays idle. After reset a clearing pass writes zero to all
// 2048 glyph store entries, one per cycle, with busy high. Each result appears in the
// cycle after it is formed; the receiver cannot stall, so no result is ever held back.
`default_nettype none

module glyph_text_renderer (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire gtr_pkg::req_type req_data,
   output logic                 rsp_valid,
   output gtr_pkg::rsp_type     rsp_data
);
   import gtr_pkg::*;

   // Glyph store: one entry per glyph row, bit 7 is the leftmost pixel.
   logic [7:0] glyph_mem [STORE_DEPTH];

   state_type             state_ff, state_in;
   logic [STORE_AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [STORE_AW-1:0]   ld_addr_ff, ld_addr_in;
   logic [2:0]            ld_col_ff, ld_col_in;
   logic [7:0]            char_ff, char_in;
   logic [5:0]            pix_cnt_ff, pix_cnt_in;
   logic [CUR_COL_W-1:0]  cursor_col_ff, cursor_col_in;
   logic [CUR_ROW_W-1:0]  cursor_row_ff, cursor_row_in;
   logic [7:0]            rd_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  mem_we;
   logic [STORE_AW-1:0]   mem_waddr;
   logic [7:0]            mem_wdata;
   logic                  mem_re;
   logic [STORE_AW-1:0]   mem_raddr;
   logic                  emit;
   logic [2:0]            glyph_row;
   logic [2:0]            glyph_col;
   logic [COL_SUM_W-1:0]  col_sum;
   logic [ROW_SUM_W-1:0]  row_sum;
   logic [COL_SUM_W-1:0]  next_col;
   logic [ROW_SUM_W-1:0]  next_row;

   assign accept    = start && !busy;
   assign glyph_row = pix_cnt_ff[5:3];
   assign glyph_col = pix_cnt_ff[2:0];

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == STORE_AW'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_DRAW) begin
                  state_in = ST_FETCH;
               end else if (req_data.sheet_bit) begin
                  state_in = ST_LD_RD;
               end
            end
         end
         ST_LD_RD: state_in = ST_LD_WR;
         ST_LD_WR: state_in = ST_IDLE;
         ST_FETCH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (pix_cnt_ff == 6'd63) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory port controls and handshake outputs of each state.
   always_comb begin
      busy      = 1'b1;
      mem_we    = 1'b0;
      mem_waddr = ld_addr_ff;
      mem_wdata = rd_data_ff | (8'h80 >> ld_col_ff);
      mem_re    = 1'b0;
      mem_raddr = ld_addr_ff;
      emit      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = 8'h00;
         end
         ST_IDLE: busy = 1'b0;
         ST_LD_RD: mem_re = 1'b1;
         ST_LD_WR: mem_we = 1'b1;
         ST_FETCH: begin
            mem_re    = 1'b1;
            mem_raddr = {char_ff, 3'd0};
         end
         ST_EMIT: begin
            emit = 1'b1;
            // Fetch the next glyph row during the last pixel of this one.
            if (glyph_col == 3'd7 && glyph_row != 3'd7) begin
               mem_re    = 1'b1;
               mem_raddr = {char_ff, glyph_row + 3'd1};
            end
         end
         default: busy = 1'b1;
      endcase
   end

   // Pixel coordinates and the cursor advance with line and screen wrap.
   always_comb begin
      col_sum  = COL_SUM_W'(cursor_col_ff) + COL_SUM_W'(glyph_col);
      row_sum  = ROW_SUM_W'(cursor_row_ff) + ROW_SUM_W'(glyph_row);
      next_col = COL_SUM_W'(cursor_col_ff) + COL_SUM_W'(GLYPH_DIM);
      next_row = ROW_SUM_W'(cursor_row_ff);
      if (next_col + COL_SUM_W'(GLYPH_DIM) > COL_SUM_W'(SCREEN_WIDTH)) begin
         next_col = '0;
         next_row = ROW_SUM_W'(cursor_row_ff) + ROW_SUM_W'(GLYPH_DIM);
         if (next_row + ROW_SUM_W'(GLYPH_DIM) > ROW_SUM_W'(SCREEN_HEIGHT)) begin
            next_row = '0;
         end
      end
   end

   // Next values of the datapath registers.
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      ld_addr_in    = ld_addr_ff;
      ld_col_in     = ld_col_ff;
      char_in       = char_ff;
      pix_cnt_in    = pix_cnt_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      rsp_valid_in  = emit;
      rsp_data_in.pixel_col  = col_sum[PIX_COL_W-1:0];
      rsp_data_in.pixel_row  = row_sum[PIX_ROW_W-1:0];
      rsp_data_in.pixel_on   = rd_data_ff[3'd7 - glyph_col];
      rsp_data_in.last_pixel = (pix_cnt_ff == 6'd63);
      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + STORE_AW'(1);
      end
      if (accept) begin
         // Sheet pixel (row, col) lands in glyph (row/8)*16 + col/8, row row%8.
         ld_addr_in = {req_data.sheet_row[6:3], req_data.sheet_col[6:3],
                       req_data.sheet_row[2:0]};
         ld_col_in  = req_data.sheet_col[2:0];
         char_in    = req_data.char_code;
         pix_cnt_in = 6'd0;
      end
      if (emit) begin
         pix_cnt_in = pix_cnt_ff + 6'd1;
         if (pix_cnt_ff == 6'd63) begin
            cursor_col_in = next_col[CUR_COL_W-1:0];
            cursor_row_in = next_row[CUR_ROW_W-1:0];
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ld_addr_ff  <= ld_addr_in;
      ld_col_ff   <= ld_col_in;
      char_ff     <= char_in;
      pix_cnt_ff  <= pix_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Glyph store with one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         glyph_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= glyph_mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result only follows a cycle of pixel output.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("result strobe without a pixel output cycle");

   // The block is free again when the last pixel of a character is shown.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_pixel) |-> !busy)
      else $error("block still busy with the last pixel on the result port");

   // Consecutive characters are parted: no result directly follows the last pixel of a character.
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_pixel) |=> !rsp_valid)
      else $error("result right after the last pixel of a character");

   // The cursor cell fits within the line whenever the cursor column changes.
   a_cursor_fits: assert property (@(posedge clock) disable iff (reset)
      $changed(cursor_col_ff) |->
         (COL_SUM_W'(cursor_col_ff) + COL_SUM_W'(GLYPH_DIM) <=
          COL_SUM_W'(SCREEN_WIDTH)))
      else $error("cursor column moved past the last cell of the line");

endmodule

`default_nettype wire
